FILE: sv/sbs_pkg.sv
package sbs_pkg;

  localparam int MAX_READINGS = 128;

  localparam int VAL_W      = 15;
  localparam int RDG_W      = 16;
  localparam int SUM_W      = 22;
  localparam int CNT_W      = $clog2(MAX_READINGS + 1);
  localparam int POS_W      = (MAX_READINGS > 1) ? $clog2(MAX_READINGS) : 1;
  localparam int OUT_CNT_W  = 8;
  localparam int OUT_IDX_W  = 7;
  localparam int DIV_STEPS  = SUM_W;
  localparam int DIV_CNT_W  = $clog2(DIV_STEPS);
  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 4;

  localparam logic [CNT_W-1:0]     CNT_MAX      = CNT_W'(MAX_READINGS);
  localparam logic [POS_W-1:0]     POS_LAST     = POS_W'(MAX_READINGS - 1);
  localparam logic [DIV_CNT_W-1:0] DIV_LAST     = DIV_CNT_W'(DIV_STEPS - 1);

  localparam logic [VAL_W-1:0] WARN_RST = 15'd7680;
  localparam logic [VAL_W-1:0] CRIT_RST = 15'd11520;
  localparam logic [VAL_W-1:0] SHUT_RST = 15'd15360;

  typedef enum logic [1:0] {
    REG_WARN = 2'd0,
    REG_CRIT = 2'd1,
    REG_SHUT = 2'd2
  } reg_idx_e;

  typedef enum logic [1:0] {
    BAND_NORMAL   = 2'd0,
    BAND_WARNING  = 2'd1,
    BAND_CRITICAL = 2'd2,
    BAND_SHUTDOWN = 2'd3
  } band_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_START,
    ST_DIV,
    ST_DONE
  } ctrl_state_e;

  typedef struct packed {
    logic signed [RDG_W-1:0] reading;
    logic                    last_of_batch;
  } sbs_item_t;

  typedef struct packed {
    logic [OUT_CNT_W-1:0] valid_count;
    logic [OUT_CNT_W-1:0] skipped_count;
    logic [VAL_W-1:0]     min_reading;
    logic [VAL_W-1:0]     max_reading;
    logic [VAL_W-1:0]     average_reading;
    logic [OUT_CNT_W-1:0] normal_count;
    logic [OUT_CNT_W-1:0] warning_count;
    logic [OUT_CNT_W-1:0] critical_count;
    logic [OUT_CNT_W-1:0] shutdown_count;
    logic                 critical_found;
    logic [OUT_IDX_W-1:0] critical_index;
    logic [VAL_W-1:0]     critical_value;
  } sbs_result_t;

  typedef struct packed {
    logic [VAL_W-1:0] warn;
    logic [VAL_W-1:0] crit;
    logic [VAL_W-1:0] shut;
  } sbs_thr_t;

  typedef struct packed {
    logic [VAL_W-1:0]           run_min;
    logic [VAL_W-1:0]           run_max;
    logic [SUM_W-1:0]           run_sum;
    logic [CNT_W-1:0]           good_cnt;
    logic [CNT_W-1:0]           bad_cnt;
    logic [3:0][CNT_W-1:0]      band_cnt;
    logic [POS_W-1:0]           pos;
    logic                       hit_flag;
    logic [POS_W-1:0]           hit_idx;
    logic [VAL_W-1:0]           hit_val;
  } sbs_stats_t;

  typedef struct packed {
    logic in_ready;
    logic div_start;
    logic load_out;
    logic acc_clear;
  } sbs_ctl_t;

endpackage

FILE: sv/sbs_if.sv
interface sbs_in_if import sbs_pkg::*; ();
  logic      valid;
  logic      ready;
  sbs_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface sbs_out_if import sbs_pkg::*; ();
  logic        valid;
  logic        ready;
  sbs_result_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: sv/sbs_cfg.sv
module sbs_cfg import sbs_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  output sbs_thr_t              thr_o
);

  sbs_thr_t thr_q, thr_d;
  logic     wr_en;
  reg_idx_e idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = reg_idx_e'(paddr[3:2]);

  always_comb begin
    thr_d = thr_q;
    if (wr_en) begin
      case (idx)
        REG_WARN: thr_d.warn = pwdata[VAL_W-1:0];
        REG_CRIT: thr_d.crit = pwdata[VAL_W-1:0];
        REG_SHUT: thr_d.shut = pwdata[VAL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_WARN: prdata = APB_DATA_W'(thr_q.warn);
      REG_CRIT: prdata = APB_DATA_W'(thr_q.crit);
      REG_SHUT: prdata = APB_DATA_W'(thr_q.shut);
      default:  prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q.warn <= WARN_RST;
      thr_q.crit <= CRIT_RST;
      thr_q.shut <= SHUT_RST;
    end else begin
      thr_q <= thr_d;
    end
  end

  assign thr_o = thr_q;

endmodule

FILE: sv/sbs_accum.sv
module sbs_accum import sbs_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       upd_i,
  input  logic       clear_i,
  input  sbs_item_t  item_i,
  input  sbs_thr_t   thr_i,
  output sbs_stats_t stats_o
);

  sbs_stats_t       st_q, st_d;
  logic [VAL_W-1:0] r;
  logic             neg;
  band_e            band;
  logic [SUM_W:0]   sum_ext;

  assign r       = item_i.reading[VAL_W-1:0];
  assign neg     = item_i.reading[RDG_W-1];
  assign sum_ext = {1'b0, st_q.run_sum} + (SUM_W + 1)'(r);

  // bands tested in order, no reordering of the thresholds
  always_comb begin
    if (r < thr_i.warn) begin
      band = BAND_NORMAL;
    end else if (r < thr_i.crit) begin
      band = BAND_WARNING;
    end else if (r < thr_i.shut) begin
      band = BAND_CRITICAL;
    end else begin
      band = BAND_SHUTDOWN;
    end
  end

  always_comb begin
    st_d = st_q;
    if (clear_i) begin
      st_d = '0;
    end else if (upd_i) begin
      if (neg) begin
        if (st_q.bad_cnt < CNT_MAX) st_d.bad_cnt = st_q.bad_cnt + 1'b1;
      end else begin
        if (st_q.good_cnt == '0) begin
          st_d.run_min = r;
          st_d.run_max = r;
        end else begin
          if (r < st_q.run_min) st_d.run_min = r;
          if (r > st_q.run_max) st_d.run_max = r;
        end
        // sum and count hold once the count is full
        if (st_q.good_cnt < CNT_MAX) begin
          st_d.run_sum  = sum_ext[SUM_W] ? '1 : sum_ext[SUM_W-1:0];
          st_d.good_cnt = st_q.good_cnt + 1'b1;
        end
        if (st_q.band_cnt[band] < CNT_MAX) begin
          st_d.band_cnt[band] = st_q.band_cnt[band] + 1'b1;
        end
        if (!st_q.hit_flag && (r >= thr_i.crit)) begin
          st_d.hit_flag = 1'b1;
          st_d.hit_idx  = st_q.pos;
          st_d.hit_val  = r;
        end
      end
      if (!item_i.last_of_batch && (st_q.pos != POS_LAST)) begin
        st_d.pos = st_q.pos + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '0;
    end else begin
      st_q <= st_d;
    end
  end

  assign stats_o = st_q;

endmodule

FILE: sv/sbs_div.sv
module sbs_div import sbs_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [SUM_W-1:0] dividend_i,
  input  logic [CNT_W-1:0] divisor_i,
  output logic             busy_o,
  output logic [VAL_W-1:0] quotient_o
);

  logic                 busy_q, busy_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [CNT_W-1:0]     rem_q, rem_d;
  logic [SUM_W-1:0]     quo_q, quo_d;
  logic [CNT_W-1:0]     dvs_q, dvs_d;
  logic [CNT_W:0]       trial;
  logic [CNT_W:0]       diff;
  logic                 ge;

  // restoring step: one quotient bit a cycle, dividend shifts out as quotient shifts in
  assign trial = {rem_q, quo_q[SUM_W-1]};
  assign diff  = trial - {1'b0, dvs_q};
  assign ge    = trial >= {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      quo_d  = dividend_i;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      rem_d = ge ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
      quo_d = {quo_q[SUM_W-2:0], ge};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == DIV_LAST) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign busy_o     = busy_q;
  assign quotient_o = quo_q[VAL_W-1:0];

  a_div_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && !start_i && (cnt_q == DIV_LAST)) |=> !busy_q)
    else $error("divider did not finish after its last step");

  a_div_remainder: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && !start_i && (dvs_q != '0)) |=> (rem_q < dvs_q))
    else $error("divider remainder not below divisor");

endmodule

FILE: sv/sbs_ctrl.sv
module sbs_ctrl import sbs_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  logic     last_i,
  input  logic     div_busy_i,
  input  logic     out_free_i,
  output sbs_ctl_t ctl_o
);

  ctrl_state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (in_valid_i && last_i) state_d = ST_START;
      ST_START: state_d = ST_DIV;
      ST_DIV:   if (!div_busy_i) state_d = ST_DONE;
      ST_DONE:  if (out_free_i) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    ctl_o = '0;
    case (state_q)
      ST_IDLE:  ctl_o.in_ready = 1'b1;
      ST_START: ctl_o.div_start = 1'b1;
      ST_DIV:   ;
      ST_DONE: begin
        ctl_o.load_out  = out_free_i;
        ctl_o.acc_clear = out_free_i;
      end
      default:  ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

FILE: sv/sensor_batch_statistics.sv
// Batch statistics over signed Q8.8 temperature readings. Each input word is
// one reading plus a last-of-batch flag; negative readings are counted as
// skipped, the rest update min, max, sum, count, four threshold bands and the
// first reading at or above the critical threshold. A word without the flag
// is accepted and the input stays ready. A word with the flag
// stalls the input while the restoring divider forms the average one
// quotient bit per clock from the 22-bit sum; then, once the output register
// is free, the summary word is loaded into it and the batch state is
// cleared. The summary waits there until taken while new readings flow in.
// Thresholds sit on the APB port at byte addresses 0, 4 and 8 and should
// only be written between batches.
module sensor_batch_statistics import sbs_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  sbs_in_if.sink                in_i,
  sbs_out_if.source             out_o
);

  sbs_thr_t         thr;
  sbs_stats_t       stats;
  sbs_ctl_t         ctl;
  logic             acc_upd;
  logic             div_busy;
  logic [VAL_W-1:0] quotient;
  logic             out_free;
  logic             out_valid_q, out_valid_d;
  sbs_result_t      out_data_q, res;
  logic             any_good;

  assign in_i.ready = ctl.in_ready;
  assign acc_upd    = in_i.valid & ctl.in_ready;
  assign out_free   = !out_valid_q || out_o.ready;

  sbs_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .thr_o   (thr)
  );

  sbs_accum u_accum (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .upd_i   (acc_upd),
    .clear_i (ctl.acc_clear),
    .item_i  (in_i.data),
    .thr_i   (thr),
    .stats_o (stats)
  );

  sbs_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (ctl.div_start),
    .dividend_i (stats.run_sum),
    .divisor_i  (stats.good_cnt),
    .busy_o     (div_busy),
    .quotient_o (quotient)
  );

  sbs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .last_i     (in_i.data.last_of_batch),
    .div_busy_i (div_busy),
    .out_free_i (out_free),
    .ctl_o      (ctl)
  );

  assign any_good = stats.good_cnt != '0;

  always_comb begin
    res.valid_count     = OUT_CNT_W'(stats.good_cnt);
    res.skipped_count   = OUT_CNT_W'(stats.bad_cnt);
    res.min_reading     = any_good ? stats.run_min : '0;
    res.max_reading     = any_good ? stats.run_max : '0;
    res.average_reading = any_good ? quotient : '0;
    res.normal_count    = OUT_CNT_W'(stats.band_cnt[BAND_NORMAL]);
    res.warning_count   = OUT_CNT_W'(stats.band_cnt[BAND_WARNING]);
    res.critical_count  = OUT_CNT_W'(stats.band_cnt[BAND_CRITICAL]);
    res.shutdown_count  = OUT_CNT_W'(stats.band_cnt[BAND_SHUTDOWN]);
    res.critical_found  = stats.hit_flag;
    res.critical_index  = OUT_IDX_W'(stats.hit_idx);
    res.critical_value  = stats.hit_val;
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (ctl.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl.load_out) out_data_q <= res;
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_data_q;

  a_no_accept_while_dividing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl.in_ready |-> !div_busy)
    else $error("input ready while the divider is running");

  a_load_into_free_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl.load_out |-> (!out_valid_q || out_o.ready))
    else $error("summary loaded over an untaken word");

  a_start_runs_divider: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl.div_start |=> div_busy)
    else $error("divider not busy after start");

  a_count_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (stats.good_cnt <= CNT_MAX) && (stats.bad_cnt <= CNT_MAX))
    else $error("reading count beyond its saturation limit");

endmodule
